### rtl/brfifo_pkg.sv
`default_nettype none

package brfifo_pkg;

	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int SIZE_W    = 13;
	localparam int LEN_W     = 13;
	localparam int ADV_W     = 13;
	localparam int OFF_W     = 12;
	localparam int CNT_W     = 12;
	localparam int MOD_STEPS = ADV_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam int SIZE_RESET = 4096;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] data_byte;
		logic              message_first;
		logic [LEN_W-1:0]  message_length;
		logic [ADV_W-1:0]  advance_count;
		logic [OFF_W-1:0]  read_offset;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] read_data;
		logic [CNT_W-1:0]  run_length;
		logic [CNT_W-1:0]  read_address;
		logic [CNT_W-1:0]  free_bytes;
		logic [CNT_W-1:0]  used_bytes;
		logic              empty_res;
	} out_item_t;

endpackage

`default_nettype wire

### rtl/byte_ring_fifo_message_admit.sv
`default_nettype none

// circular byte fifo, one slot always left empty, with whole-message admission
// command channel: an item is taken at a clock edge with start high and busy low
// result channel: done is high for one cycle with result; the receiver cannot
// stall it, and a new item may be taken in that same cycle
// config channel: cfg_data is the ring size, taken when cfg_valid and cfg_ready;
// cfg_ready is low while busy; the size is clamped to 2..DEPTH and a write
// clears both pointers and the drop flag
// write and unused operations: busy never rises and done is registered at the
// accepting edge; bytes can be taken every cycle while no read or advance runs
// read and advance: the offset or count is reduced modulo the ring size in a
// bit-serial remainder loop (ST_MOD), one bit a cycle over 13 bits, then ST_FIN
// adds the read pointer and wraps (read also issues the memory read there);
// busy through ST_MOD and ST_FIN, and done is registered as ST_FIN ends
// free, used and empty always describe the state after the item
// reset: pointers zero, no message being dropped, ring size min(4096, DEPTH);
// byte memory not cleared; user must write entries before reading: not enforced
module byte_ring_fifo_message_admit #(
	parameter int DEPTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire brfifo_pkg::in_item_t  cmd,
	output logic                       done,
	output brfifo_pkg::out_item_t      result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [brfifo_pkg::SIZE_W-1:0] cfg_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int SW = ($clog2(DEPTH + 1) > brfifo_pkg::SIZE_W) ?
		$clog2(DEPTH + 1) : brfifo_pkg::SIZE_W;
	localparam int RST_SIZE = (DEPTH < brfifo_pkg::SIZE_RESET) ?
		DEPTH : brfifo_pkg::SIZE_RESET;

	typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_FIN} state_t;

	state_t state_q;

	logic [PW-1:0]                      wp_q;
	logic [PW-1:0]                      rp_q;
	logic                               drop_q;
	logic [SW-1:0]                      eff_q;
	logic [SW:0]                        rem_q;
	logic [brfifo_pkg::ADV_W-1:0]       dvd_q;
	logic [brfifo_pkg::MOD_CNT_W-1:0]   cnt_q;
	logic                               adv_q;
	logic                               done_q;
	logic                               acc_q;
	logic                               rd_q;
	logic [brfifo_pkg::CNT_W-1:0]       run_q;
	logic [brfifo_pkg::CNT_W-1:0]       raddr_q;

	logic [brfifo_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [brfifo_pkg::BYTE_W-1:0] mem_q;

	logic [SW-1:0] wp_x;
	logic [SW-1:0] rp_x;
	logic [SW-1:0] free_cnt;
	logic [SW-1:0] used_cnt;
	logic [SW-1:0] run_calc;
	logic [SW-1:0] wp_inc;
	logic [SW-1:0] len_x;
	logic [SW-1:0] cfg_x;
	logic [SW-1:0] size_nx;
	logic [SW:0]   mod_t;
	logic [SW:0]   rem_nx;
	logic [SW:0]   sum;
	logic [SW:0]   sum_w;
	logic [PW-1:0] tgt;
	logic          accept;
	logic          drop_nx;
	logic          wr_en;
	logic          rd_en;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign wp_x      = SW'(wp_q);
	assign rp_x      = SW'(rp_q);
	assign len_x     = SW'(cmd.message_length);
	assign cfg_x     = SW'(cfg_data);

	always_comb begin
		if (rp_x > wp_x) begin
			free_cnt = SW'(rp_x - wp_x - SW'(1));
		end else begin
			free_cnt = SW'({1'b0, rp_x} + {1'b0, eff_q} - {1'b0, wp_x} - (SW+1)'(1));
		end
		if (wp_x >= rp_x) begin
			used_cnt = SW'(wp_x - rp_x);
		end else begin
			used_cnt = SW'({1'b0, wp_x} + {1'b0, eff_q} - {1'b0, rp_x});
		end
		if (wp_x > rp_x) begin
			run_calc = SW'(wp_x - rp_x);
		end else if (wp_x < rp_x) begin
			run_calc = SW'(eff_q - rp_x);
		end else begin
			run_calc = '0;
		end
	end

	// admission check on a message's first byte, else the flag carries on
	always_comb begin
		if (cmd.message_first) begin
			drop_nx = (len_x == '0) || (len_x > free_cnt);
		end else begin
			drop_nx = drop_q;
		end
		wr_en  = accept && (cmd.operation == brfifo_pkg::OP_WRITE) && !drop_nx &&
			(free_cnt != '0);
		wp_inc = SW'(wp_x + SW'(1));
		if (wp_inc == eff_q) begin
			wp_inc = '0;
		end
	end

	// one remainder bit a cycle, value stays below twice the size
	always_comb begin
		mod_t  = {rem_q[SW-1:0], dvd_q[brfifo_pkg::ADV_W-1]};
		rem_nx = (mod_t >= {1'b0, eff_q}) ? (mod_t - {1'b0, eff_q}) : mod_t;
		sum    = rem_q + {1'b0, rp_x};
		sum_w  = (sum >= {1'b0, eff_q}) ? (sum - {1'b0, eff_q}) : sum;
		tgt    = sum_w[PW-1:0];
		rd_en  = (state_q == ST_FIN) && !adv_q;
	end

	always_comb begin
		if (cfg_x < SW'(2)) begin
			size_nx = SW'(2);
		end else if (cfg_x > SW'(DEPTH)) begin
			size_nx = SW'(DEPTH);
		end else begin
			size_nx = cfg_x;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= cmd.data_byte;
		end
		if (rd_en) begin
			mem_q <= mem[tgt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			drop_q  <= 1'b0;
			eff_q   <= SW'(RST_SIZE);
			rem_q   <= '0;
			dvd_q   <= '0;
			cnt_q   <= '0;
			adv_q   <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
			rd_q    <= 1'b0;
			run_q   <= '0;
			raddr_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						acc_q   <= 1'b0;
						rd_q    <= 1'b0;
						run_q   <= '0;
						raddr_q <= '0;
						case (cmd.operation) inside
							brfifo_pkg::OP_WRITE: begin
								done_q <= 1'b1;
								drop_q <= drop_nx;
								if (wr_en) begin
									acc_q <= 1'b1;
									wp_q  <= wp_inc[PW-1:0];
								end
							end
							brfifo_pkg::OP_READ, brfifo_pkg::OP_ADVANCE: begin
								state_q <= ST_MOD;
								rem_q   <= '0;
								cnt_q   <= '0;
								adv_q   <= (cmd.operation == brfifo_pkg::OP_ADVANCE);
								if (cmd.operation == brfifo_pkg::OP_ADVANCE) begin
									dvd_q <= cmd.advance_count;
								end else begin
									dvd_q <= brfifo_pkg::ADV_W'(cmd.read_offset);
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
					if (cfg_valid) begin
						eff_q  <= size_nx;
						wp_q   <= '0;
						rp_q   <= '0;
						drop_q <= 1'b0;
					end
				end
				ST_MOD: begin
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + brfifo_pkg::MOD_CNT_W'(1);
					if (cnt_q == brfifo_pkg::MOD_CNT_W'(brfifo_pkg::MOD_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (adv_q) begin
						rp_q <= tgt;
					end else begin
						rd_q    <= 1'b1;
						run_q   <= run_calc[brfifo_pkg::CNT_W-1:0];
						raddr_q <= rp_x[brfifo_pkg::CNT_W-1:0];
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done                = done_q;
	assign result.accepted     = acc_q;
	assign result.read_data    = rd_q ? mem_q : '0;
	assign result.run_length   = run_q;
	assign result.read_address = raddr_q;
	assign result.free_bytes   = free_cnt[brfifo_pkg::CNT_W-1:0];
	assign result.used_bytes   = used_cnt[brfifo_pkg::CNT_W-1:0];
	assign result.empty_res    = (wp_q == rp_q);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_x < eff_q) && (rp_x < eff_q))
		else $error("pointer outside ring size");

	a_slow_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((cmd.operation == brfifo_pkg::OP_READ) ||
		(cmd.operation == brfifo_pkg::OP_ADVANCE)) |=> busy && !done)
		else $error("read or advance not held busy");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> (wp_q == '0) && (rp_q == '0) && !drop_q)
		else $error("size write did not clear pointers");

	a_acc_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (free_cnt != '0) && (state_q == ST_IDLE))
		else $error("byte stored with no free slot");

endmodule

`default_nettype wire
